### rtl/core/uv_sphere_tessellator_assert.svh
// assertion macros for the uv sphere tessellator
`ifndef UV_SPHERE_TESSELLATOR_ASSERT_SVH
`define UV_SPHERE_TESSELLATOR_ASSERT_SVH
// implication checked on every clock edge out of reset
`define UST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define UST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/core/ust_pkg.sv
// package for the uv sphere tessellator: constants, types and the cordic angle table
`default_nettype none
package ust_pkg;
  localparam int unsigned FracBits = 14;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned MaxCount = 256;
  localparam logic [31:0] CordicGain = 32'd652032874;
  localparam logic [1:0] CfgRadius = 2'd0;
  localparam logic [1:0] CfgSegments = 2'd1;
  localparam logic [1:0] CfgRings = 2'd2;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [14:0] tex_u;
    logic [14:0] tex_v;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
  } vert_t;

  typedef struct packed {
    logic last;
    logic bad;
  } flags_t;

  function automatic logic signed [32:0] atan_ba(input logic [4:0] i);
    logic signed [32:0] r;
    r = '0;
    case (i)
      5'd0: r = 33'sd536870912;  5'd1: r = 33'sd316933406;
      5'd2: r = 33'sd167458907;  5'd3: r = 33'sd85004756;
      5'd4: r = 33'sd42667331;   5'd5: r = 33'sd21354465;
      5'd6: r = 33'sd10679838;   5'd7: r = 33'sd5340245;
      5'd8: r = 33'sd2670163;    5'd9: r = 33'sd1335087;
      5'd10: r = 33'sd667544;    5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;    5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;     5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;     5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;       5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;       5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;        5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;        5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;         5'd29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round half away from zero, shift right by s
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] v,
                                                 input int unsigned s);
    logic signed [47:0] m;
    logic signed [47:0] h;
    h = 48'sd1 <<< (s - 1);
    m = v[47] ? -v : v;
    m = (m + h) >>> s;
    return v[47] ? -m : m;
  endfunction
endpackage
`default_nettype wire

### rtl/core/uv_sphere_tessellator.sv
// top level of the uv sphere tessellator
// usage:
//   s_axis carries one tile per transfer, tdata = {column, row}.
//   m_axis returns vertices; tdata packs pos_x, pos_y, pos_z, tex_u, tex_v,
//   norm_x, norm_y, norm_z from the low bits, tuser = {bad_index}, tlast marks
//   the sixth vertex of a tile.
//   cfg channel writes radius (0), segment_count (1), ring_count (2).
// a valid tile gives six vertices, a tile out of range gives one flagged result.
// one vertex enters the pipeline per cycle while the output is not stalled; an
// out of range tile leaves the sequencer idle, and s_axis_tready is low while the vertex
// sequencer walks the six corners of a tile.
// m_axis_tvalid rises once the input transfer has passed 15 divider stages,
// 31 cordic stages, then product, normal, position and output registers.
// when m_axis_tready is low and the output register holds a vertex the whole pipeline holds; nothing is lost.
// reset loads radius 256, 32 segments and 16 rings and empties the pipeline.
`default_nettype none
module uv_sphere_tessellator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // row, column
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [127:0]     m_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x..z
  output logic             m_axis_tuser,   // bad_index
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);
  `include "uv_sphere_tessellator_assert.svh"

  logic [14:0] radius_q;
  logic [8:0]  segs_q, rings_q;
  logic [8:0]  segs, rings;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [7:0]  row_q, col_q;
  logic        en;
  logic        take;
  logic        bad;
  logic        pv;
  logic [8:0]  pcol, prow;
  ust_pkg::flags_t pfl;
  logic        ov;
  ust_pkg::vert_t vo;
  ust_pkg::flags_t fo;
  logic        out_v_q;
  ust_pkg::vert_t out_q;
  ust_pkg::flags_t outf_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 15'd256;
      segs_q <= 9'd32;
      rings_q <= 9'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ust_pkg::CfgRadius: radius_q <= cfg_data_i;
        ust_pkg::CfgSegments: segs_q <= cfg_data_i[8:0];
        ust_pkg::CfgRings: rings_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign segs = (segs_q > 9'(ust_pkg::MaxCount)) ? 9'(ust_pkg::MaxCount) : segs_q;
  assign rings = (rings_q > 9'(ust_pkg::MaxCount)) ? 9'(ust_pkg::MaxCount) : rings_q;

  // pipeline advances unless the output register is full and stalled
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en && !busy_q;
  assign take = s_axis_tvalid && s_axis_tready;
  assign bad = ({1'b0, s_axis_tdata[7:0]} >= rings) ||
               ({1'b0, s_axis_tdata[15:8]} >= segs);

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    if (en) begin
      if (busy_q) begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          busy_d = 1'b0;
          cnt_d = '0;
        end
      end else if (take && !bad) begin
        busy_d = 1'b1;
        cnt_d = 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      row_q <= s_axis_tdata[7:0];
      col_q <= s_axis_tdata[15:8];
    end
  end

  // corner offsets: di = 0,0,1,0,1,1 and dj = 0,1,1,0,1,0
  always_comb begin
    logic [7:0] r, c;
    logic di, dj;
    r = busy_q ? row_q : s_axis_tdata[7:0];
    c = busy_q ? col_q : s_axis_tdata[15:8];
    di = 1'b0;
    dj = 1'b0;
    case (busy_q ? cnt_q : 3'd0)
      3'd0: begin di = 1'b0; dj = 1'b0; end
      3'd1: begin di = 1'b0; dj = 1'b1; end
      3'd2: begin di = 1'b1; dj = 1'b1; end
      3'd3: begin di = 1'b0; dj = 1'b0; end
      3'd4: begin di = 1'b1; dj = 1'b1; end
      3'd5: begin di = 1'b1; dj = 1'b0; end
      default: begin di = 1'b0; dj = 1'b0; end
    endcase
    pcol = {1'b0, c} + {8'd0, di};
    prow = {1'b0, r} + {8'd0, dj};
    pv = busy_q || take;
    pfl.bad = !busy_q && bad;
    pfl.last = busy_q && (cnt_q == 3'd5);
  end

  ust_vertex_pipe u_pipe (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv), .col_i(pcol), .row_i(prow),
    .segs_i(segs), .rings_i(rings), .radius_i(radius_q), .flags_i(pfl),
    .valid_o(ov), .vert_o(vo), .flags_o(fo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= ov;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= vo;
      outf_q <= fo;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {2'd0, out_q.norm_z, out_q.norm_y, out_q.norm_x,
                         out_q.tex_v, out_q.tex_u, out_q.pos_z, out_q.pos_y,
                         out_q.pos_x};
  assign m_axis_tuser = outf_q.bad;
  assign m_axis_tlast = outf_q.last;

  `UST_ASSERT_IMP(a_no_take_busy, busy_q, !s_axis_tready)
  `UST_ASSERT_IMP(a_cnt_range, busy_q, cnt_q != 3'd0 && cnt_q <= 3'd5)
  `UST_ASSERT_NXT(a_hold_stall, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata))
  `UST_ASSERT_IMP(a_flags_excl, m_axis_tvalid, !(m_axis_tlast && m_axis_tuser))
endmodule
`default_nettype wire

### rtl/core/ust_grid_div.sv
// pipelined restoring divider computing round(idx * 2^14 / n) for u or v
`default_nettype none
module ust_grid_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [8:0]  idx_i,
  input  wire logic [8:0]  n_i,
  output logic [14:0]      frac_o
);
  // numerator (idx << 15) + n, divisor 2n; quotient at most 2^14 fits 15 bits
  localparam int unsigned QW = 15;
  logic [24:0]   num_q [1:QW];
  logic [9:0]    den_q [1:QW];
  logic [QW-1:0] quo_q [1:QW];

  // top 10 bits of numerator below 2^10; 2n >= 2 when n >= 1, quotient bits from bit 14 down
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [24:0]   num;
    logic [9:0]    den;
    logic [QW-1:0] quo;
    logic [35:0]   part;
    logic [35:0]   dsh;
    if (k == 0) begin : g_first
      assign num = {1'b0, idx_i, 15'd0} + {16'd0, n_i};
      assign den = {n_i, 1'b0};
      assign quo = '0;
    end else begin : g_next
      assign num = num_q[k];
      assign den = den_q[k];
      assign quo = quo_q[k];
    end
    always_comb begin
      part = {11'd0, num};
      dsh = {26'd0, den} << (QW - 1 - k);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k+1] <= den;
        if (part >= dsh) begin
          num_q[k+1] <= 25'(part - dsh);
          quo_q[k+1] <= quo | (QW'(1) << (QW - 1 - k));
        end else begin
          num_q[k+1] <= num;
          quo_q[k+1] <= quo;
        end
      end
    end
  end

  assign frac_o = quo_q[QW];
endmodule
`default_nettype wire

### rtl/core/ust_cordic.sv
// pipelined rotation cordic returning cos and sin in q1.14 of a binary angle
`default_nettype none
module ust_cordic (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] ang_i,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);
  localparam int unsigned N = ust_pkg::CordicSteps;
  logic signed [33:0] x_q [1:N];
  logic signed [33:0] y_q [1:N];
  logic signed [32:0] z_q [1:N];
  logic [1:0]         qd_q [1:N];
  logic [31:0] d;
  logic [1:0]  q0;
  logic signed [15:0] cr_q, sr_q;
  logic [1:0] qf_q;

  always_comb begin
    q0 = 2'((ang_i + 32'h2000_0000) >> 30);
    d = ang_i - {q0, 30'd0};
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    logic signed [33:0] xs, ys;
    logic signed [32:0] zs;
    logic [1:0]         qs;
    if (i == 0) begin : g_first
      assign xs = 34'(ust_pkg::CordicGain);
      assign ys = '0;
      assign zs = {d[31], d};
      assign qs = q0;
    end else begin : g_next
      assign xs = x_q[i];
      assign ys = y_q[i];
      assign zs = z_q[i];
      assign qs = qd_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[i+1] <= qs;
        if (!zs[32]) begin
          x_q[i+1] <= xs - (ys >>> i);
          y_q[i+1] <= ys + (xs >>> i);
          z_q[i+1] <= zs - ust_pkg::atan_ba(5'(i));
        end else begin
          x_q[i+1] <= xs + (ys >>> i);
          y_q[i+1] <= ys - (xs >>> i);
          z_q[i+1] <= zs + ust_pkg::atan_ba(5'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q <= 16'(ust_pkg::rnd_shift(48'(x_q[N]), 30 - ust_pkg::FracBits));
      sr_q <= 16'(ust_pkg::rnd_shift(48'(y_q[N]), 30 - ust_pkg::FracBits));
      qf_q <= qd_q[N];
    end
  end

  always_comb begin
    cos_o = cr_q;
    sin_o = sr_q;
    case (qf_q)
      2'd0: begin cos_o = cr_q;  sin_o = sr_q;  end
      2'd1: begin cos_o = -sr_q; sin_o = cr_q;  end
      2'd2: begin cos_o = -cr_q; sin_o = -sr_q; end
      default: begin cos_o = sr_q; sin_o = -cr_q; end
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/ust_vertex_pipe.sv
// vertex pipeline: grid fractions, angles, cordic, normal and position products
`default_nettype none
module ust_vertex_pipe (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [8:0]  col_i,
  input  wire logic [8:0]  row_i,
  input  wire logic [8:0]  segs_i,
  input  wire logic [8:0]  rings_i,
  input  wire logic [14:0] radius_i,
  input  ust_pkg::flags_t  flags_i,
  output logic             valid_o,
  output ust_pkg::vert_t   vert_o,
  output ust_pkg::flags_t  flags_o
);
  // pipeline: DivLat divider + CorLat cordic + product, normal and position registers = Lat
  localparam int unsigned DivLat = 15;
  localparam int unsigned CorLat = 31;
  localparam int unsigned Lat = DivLat + CorLat + 3;

  logic [14:0] u, v;
  logic signed [15:0] cth, sth, cph, sph;
  logic [Lat-1:0] vld_q;
  ust_pkg::flags_t fl_q [Lat];
  logic [14:0] rad_q [Lat];
  logic [14:0] u_q [CorLat+2];
  logic [14:0] v_q [CorLat+2];
  logic signed [31:0] px_q, pz_q;
  logic signed [15:0] cth_q;
  logic signed [15:0] nx, ny, nz;
  logic signed [15:0] nx_q, ny_q, nz_q;
  ust_pkg::vert_t vert_q;

  ust_grid_div u_div_u (.clk_i, .en_i, .idx_i(col_i), .n_i(segs_i), .frac_o(u));
  ust_grid_div u_div_v (.clk_i, .en_i, .idx_i(row_i), .n_i(rings_i), .frac_o(v));

  ust_cordic u_cor_th (.clk_i, .en_i, .ang_i({v, 17'd0}), .cos_o(cth), .sin_o(sth));
  ust_cordic u_cor_ph (.clk_i, .en_i, .ang_i({u[13:0], 18'd0}), .cos_o(cph),
                       .sin_o(sph));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl_q[0] <= flags_i;
      rad_q[0] <= radius_i;
      for (int k = 1; k < Lat; k++) begin
        fl_q[k] <= fl_q[k-1];
        rad_q[k] <= rad_q[k-1];
      end
      u_q[0] <= u;
      v_q[0] <= v;
      for (int k = 1; k < CorLat + 2; k++) begin
        u_q[k] <= u_q[k-1];
        v_q[k] <= v_q[k-1];
      end
      px_q <= sth * cph;
      pz_q <= sth * sph;
      cth_q <= cth;
    end
  end

  function automatic logic signed [15:0] sat_unit(input logic signed [47:0] a);
    logic signed [15:0] r;
    r = a[15:0];
    if (a > 48'sd16384) r = 16'sd16384;
    else if (a < -48'sd16384) r = -16'sd16384;
    return r;
  endfunction

  function automatic logic signed [15:0] pos_of(input logic [14:0] r,
                                                input logic signed [15:0] n);
    logic signed [47:0] p;
    logic signed [15:0] o;
    p = ust_pkg::rnd_shift(48'($signed({1'b0, r})) * 48'(n), ust_pkg::FracBits);
    o = p[15:0];
    if (p > 48'sd32767) o = 16'sh7fff;
    else if (p < -48'sd32768) o = 16'sh8000;
    return o;
  endfunction

  always_comb begin
    nx = sat_unit(ust_pkg::rnd_shift(48'(px_q), ust_pkg::FracBits));
    nz = sat_unit(ust_pkg::rnd_shift(48'(pz_q), ust_pkg::FracBits));
    ny = sat_unit(48'(cth_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q <= nx;
      ny_q <= ny;
      nz_q <= nz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vert_q.norm_x <= nx_q;
      vert_q.norm_y <= ny_q;
      vert_q.norm_z <= nz_q;
      vert_q.pos_x <= pos_of(rad_q[Lat-2], nx_q);
      vert_q.pos_y <= pos_of(rad_q[Lat-2], ny_q);
      vert_q.pos_z <= pos_of(rad_q[Lat-2], nz_q);
      vert_q.tex_u <= u_q[CorLat+1];
      vert_q.tex_v <= v_q[CorLat+1];
    end
  end

  always_comb begin
    valid_o = vld_q[Lat-1];
    flags_o = fl_q[Lat-1];
    vert_o = vert_q;
    if (fl_q[Lat-1].bad) vert_o = '0;
  end
endmodule
`default_nettype wire

### sim/testbench.sv
// testbench for the uv sphere tessellator: stream stimulus, own predictor and scoreboard
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  localparam logic [1:0] CfgNone = 2'd3;

  typedef struct {
    ust_pkg::vert_t v;
    logic  last;
    logic  bad;
  } vertex_exp_t;

  class tile_scoreboard;
    vertex_exp_t pending[$];
    int unsigned radius_q = 256, segs_q = 32, rings_q = 16;
    int errors = 0, vertices = 0, rejects = 0, tiles = 0;

    function void set_reg(logic [1:0] idx, logic [14:0] val);
      if (idx == ust_pkg::CfgRadius) radius_q = val;
      else if (idx == ust_pkg::CfgSegments) segs_q = val[8:0];
      else if (idx == ust_pkg::CfgRings) rings_q = val[8:0];
    endfunction

    function void add_pending(vertex_exp_t e);
      pending.insert(pending.size(), e);
    endfunction

    function longint round_away(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void cordic(longint ang, output longint c, output longint s);
      longint q, d, z, x, y, nx, cr, sr;
      q = ((ang + 64'h2000_0000) >> 30) & 3;
      d = (ang - (q << 30)) & 64'hFFFF_FFFF;
      z = (d >= 64'h8000_0000) ? d - 64'h1_0000_0000 : d;
      x = ust_pkg::CordicGain;
      y = 0;
      for (int i = 0; i < ust_pkg::CordicSteps; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(ust_pkg::atan_ba(5'(i)));
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(ust_pkg::atan_ba(5'(i)));
        end
        x = nx;
      end
      cr = round_away(x, 30 - ust_pkg::FracBits);
      sr = round_away(y, 30 - ust_pkg::FracBits);
      case (q)
        0: begin c = cr; s = sr; end
        1: begin c = -sr; s = cr; end
        2: begin c = -cr; s = -sr; end
        default: begin c = sr; s = -cr; end
      endcase
    endfunction

    function vertex_exp_t corner(int i, int j, int segs, int rings, logic lst);
      vertex_exp_t e;
      longint u, v, cth, sth, cph, sph, n[3], p[3];
      longint one;
      one = longint'(1) << ust_pkg::FracBits;
      u = ((longint'(i) << (ust_pkg::FracBits + 1)) + segs) / (2 * segs);
      v = ((longint'(j) << (ust_pkg::FracBits + 1)) + rings) / (2 * rings);
      cordic((v << (31 - ust_pkg::FracBits)) & 64'hFFFF_FFFF, cth, sth);
      cordic((u << (32 - ust_pkg::FracBits)) & 64'hFFFF_FFFF, cph, sph);
      n[0] = clip(round_away(sth * cph, ust_pkg::FracBits), -one, one);
      n[1] = clip(cth, -one, one);
      n[2] = clip(round_away(sth * sph, ust_pkg::FracBits), -one, one);
      for (int k = 0; k < 3; k++)
        p[k] = clip(round_away(longint'(radius_q) * n[k], ust_pkg::FracBits),
                    -32768, 32767);
      e.v.pos_x = 16'(p[0]);
      e.v.pos_y = 16'(p[1]);
      e.v.pos_z = 16'(p[2]);
      e.v.tex_u = u[14:0];
      e.v.tex_v = v[14:0];
      e.v.norm_x = 16'(n[0]);
      e.v.norm_y = 16'(n[1]);
      e.v.norm_z = 16'(n[2]);
      e.last = lst;
      e.bad = 1'b0;
      return e;
    endfunction

    function void note_tile(logic [7:0] row, logic [7:0] col);
      int segs, rings;
      int di[6] = '{0, 0, 1, 0, 1, 1};
      int dj[6] = '{0, 1, 1, 0, 1, 0};
      vertex_exp_t e;
      segs = segs_q > ust_pkg::MaxCount ? ust_pkg::MaxCount : segs_q;
      rings = rings_q > ust_pkg::MaxCount ? ust_pkg::MaxCount : rings_q;
      tiles++;
      if (row >= rings || col >= segs) begin
        e.v = '0;
        e.last = 1'b0;
        e.bad = 1'b1;
        add_pending(e);
        return;
      end
      for (int k = 0; k < 6; k++)
        add_pending(corner(col + di[k], row + dj[k], segs, rings, k == 5));
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_vertex(logic [127:0] d, logic bad, logic lst);
      vertex_exp_t e;
      if (pending.size() == 0) begin
        $error("vertex transfer with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.bad) rejects++;
      else vertices++;
      cmp("pos_x", e.v.pos_x, $signed(d[15:0]));
      cmp("pos_y", e.v.pos_y, $signed(d[31:16]));
      cmp("pos_z", e.v.pos_z, $signed(d[47:32]));
      cmp("tex_u", e.v.tex_u, d[62:48]);
      cmp("tex_v", e.v.tex_v, d[77:63]);
      cmp("norm_x", e.v.norm_x, $signed(d[93:78]));
      cmp("norm_y", e.v.norm_y, $signed(d[109:94]));
      cmp("norm_z", e.v.norm_z, $signed(d[125:110]));
      cmp("last", e.last, lst);
      cmp("bad_index", e.bad, bad);
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [14:0] cfg_data_i = '0;

  tile_scoreboard sb = new();
  bit calm = 0;
  int burst = 0;
  longint cycles = 0;
  localparam longint Limit = 400000;

  uv_sphere_tessellator dut (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("uv_sphere_tessellator verification failed");
      $finish;
    end
    if (s_axis_tvalid && s_axis_tready) sb.note_tile(s_axis_tdata[7:0], s_axis_tdata[15:8]);
    if (m_axis_tvalid && m_axis_tready) sb.check_vertex(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      m_axis_tready <= 1'b1;
    end else if (burst > 0) begin
      burst--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      burst = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_tile(int row, int col);
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {col[7:0], row[7:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[14:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val[14:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_tiles(int n);
    int segs, rings;
    segs = sb.segs_q > ust_pkg::MaxCount ? ust_pkg::MaxCount : sb.segs_q;
    rings = sb.rings_q > ust_pkg::MaxCount ? ust_pkg::MaxCount : sb.rings_q;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0 || segs == 0 || rings == 0)
        send_tile($urandom_range(0, 255), $urandom_range(0, 255));
      else
        send_tile($urandom_range(0, rings - 1), $urandom_range(0, segs - 1));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_tile(0, 0);
    send_tile(15, 31);
    send_tile(16, 0);
    send_tile(0, 32);
    send_tile(255, 255);
    send_tile(7, 8);
    write_reg(ust_pkg::CfgRadius, 0);
    send_tile(3, 5);
    send_tile(15, 31);
    write_reg(ust_pkg::CfgRadius, 32767);
    write_reg(ust_pkg::CfgSegments, 256);
    write_reg(ust_pkg::CfgRings, 256);
    send_tile(255, 255);
    send_tile(0, 0);
    send_tile(128, 64);
    write_reg(ust_pkg::CfgSegments, 300);
    write_reg(ust_pkg::CfgRings, 511);
    send_tile(255, 255);
    send_tile(170, 85);
    write_reg(ust_pkg::CfgSegments, 0);
    send_tile(0, 0);
    write_reg(CfgNone, 32'h7FFF);
    write_reg(ust_pkg::CfgSegments, 1);
    write_reg(ust_pkg::CfgRings, 1);
    send_tile(0, 0);
    send_tile(1, 0);
    send_tile(0, 1);

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ust_pkg::CfgRadius, ph == 0 ? 32767 : $urandom_range(0, 32767));
      write_reg(ust_pkg::CfgSegments, ph < 2 ? 256 : $urandom_range(1, 300));
      write_reg(ust_pkg::CfgRings, ph < 2 ? 256 : $urandom_range(1, 300));
      if (ph == 4) calm = 1;
      random_tiles(19);
    end

    drain();
    $display("covered %0d tiles: %0d vertices and %0d rejected tiles", sb.tiles,
             sb.vertices, sb.rejects);
    $display("settings included zero and full radius, clamped counts and a one tile sphere");
    if (sb.errors == 0) begin
      $display("uv_sphere_tessellator verification clean");
    end else begin
      $display("uv_sphere_tessellator verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
